@@ rtl/slcpp_pkg.sv @@
// Package for the sync/length/checksum packet parser.
// Holds the byte width, framing constants, error codes and row phase codes.
// No dependencies.
package slcpp_pkg;

    localparam int unsigned DATA_W            = 8;

    localparam logic [7:0] SYNC_BYTE          = 8'hAA;
    localparam logic [7:0] ROW_CODE           = 8'h80;
    localparam logic [7:0] CHECKSUM_BASE      = 8'hFF;
    localparam logic [7:0] MAX_PAYLOAD_RESET  = 8'd169;

    // Error code reported with each result beat
    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_LENGTH   = 2'd1,
        ERR_CHECKSUM = 2'd2,
        ERR_PARSE    = 2'd3
    } err_code_t;

    // Position of a payload byte within its four-byte row
    typedef enum logic [1:0] {
        PH_CODE = 2'd0,
        PH_LEN  = 2'd1,
        PH_HIGH = 2'd2,
        PH_LOW  = 2'd3
    } row_phase_t;

endpackage

@@ rtl/sync_length_checksum_packet_parser_top.sv @@
// Sync/length/checksum serial packet parser, top level.
// Depends on slcpp_pkg.
//
// Usage:
//   Input channel: one received serial byte per beat on data_byte, moved
//   when in_valid is high and in_stall is low. Two bytes of 0xAA in a row
//   open a packet, the next byte is the payload length, then the payload
//   (rows of 0x80, ignored length, high byte, low byte), then a checksum.
//   Output channel: one result beat per input beat (packet_ok, raw_value,
//   error_code), moved when out_valid is high and out_stall is low.
//   Registers: a byte is taken into the input register and its result into
//   the result register. Throughput: one byte per cycle unless the receiver
//   stalls, set by the single pass of parser logic between the two registers.
//   When the receiver stalls, the result register holds; the input register
//   keeps taking a byte until it too is full, after which in_stall rises.
//   Reset clears all parser state, sets max_payload_length to 169 and
//   empties both registers. cfg_write_en/cfg_write_data load the maximum
//   payload length; write it only while no byte is in flight.
module sync_length_checksum_packet_parser_top (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration
    input  logic                            cfg_write_en,
    input  logic [slcpp_pkg::DATA_W-1:0]    cfg_write_data,
    // input channel
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [slcpp_pkg::DATA_W-1:0]    data_byte,
    // output channel
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            packet_ok,
    output logic [2*slcpp_pkg::DATA_W-1:0]  raw_value,
    output slcpp_pkg::err_code_t            error_code
);
    import slcpp_pkg::*;

    localparam int unsigned SAMPLE_W = 2 * DATA_W;

    // configuration register
    logic [DATA_W-1:0]   max_len_reg;

    // input register
    logic                s1_valid_reg;
    logic [DATA_W-1:0]   s1_byte_reg;

    // parser state
    logic [DATA_W-1:0]   prev_byte_reg,    prev_byte_next;
    logic                in_packet_reg,    in_packet_next;
    logic                have_len_reg,     have_len_next;
    logic [DATA_W-1:0]   byte_pos_reg,     byte_pos_next;
    logic [DATA_W-1:0]   payload_len_reg,  payload_len_next;
    logic [DATA_W-1:0]   run_sum_reg,      run_sum_next;
    row_phase_t          row_phase_reg,    row_phase_next;
    logic [SAMPLE_W-1:0] pend_sample_reg,  pend_sample_next;
    logic                pend_valid_reg,   pend_valid_next;
    logic                parse_fail_reg,   parse_fail_next;
    logic [SAMPLE_W-1:0] commit_reg,       commit_next;

    // result register
    logic                out_valid_reg;
    logic                ok_reg,           ok_next;
    err_code_t           err_reg,          err_next;
    logic [SAMPLE_W-1:0] raw_reg;

    logic                s1_fire;
    logic                s1_load;
    logic                out_free;
    logic [DATA_W-1:0]   b;

    // handshake: input register advances whenever the result register frees
    assign out_free = !out_valid_reg || !out_stall;
    assign s1_fire  = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;
    assign s1_load  = in_valid && !in_stall;
    assign b        = s1_byte_reg;

    // per-byte parser step
    always_comb
    begin
        prev_byte_next   = b;
        in_packet_next   = in_packet_reg;
        have_len_next    = have_len_reg;
        byte_pos_next    = byte_pos_reg;
        payload_len_next = payload_len_reg;
        run_sum_next     = run_sum_reg;
        row_phase_next   = row_phase_reg;
        pend_sample_next = pend_sample_reg;
        pend_valid_next  = pend_valid_reg;
        parse_fail_next  = parse_fail_reg;
        commit_next      = commit_reg;
        ok_next          = 1'b0;
        err_next         = ERR_NONE;

        if (in_packet_reg)
        begin
            priority if (!have_len_reg)
            begin
                // length byte
                payload_len_next = b;
                have_len_next    = 1'b1;
                byte_pos_next    = '0;
                if (b > max_len_reg)
                begin
                    in_packet_next = 1'b0;
                    err_next       = ERR_LENGTH;
                end
            end
            else if (byte_pos_reg < payload_len_reg)
            begin
                // payload byte: sum always, parse until the first bad row
                run_sum_next  = run_sum_reg + b;
                byte_pos_next = byte_pos_reg + 1'b1;
                if (!parse_fail_reg)
                begin
                    unique case (row_phase_reg)
                        PH_CODE:
                        begin
                            if (b != ROW_CODE)
                                parse_fail_next = 1'b1;
                            else
                                row_phase_next = PH_LEN;
                        end
                        PH_LEN:
                            row_phase_next = PH_HIGH;
                        PH_HIGH:
                        begin
                            pend_sample_next = {b, pend_sample_reg[DATA_W-1:0]};
                            row_phase_next   = PH_LOW;
                        end
                        PH_LOW:
                        begin
                            pend_sample_next = {pend_sample_reg[SAMPLE_W-1:DATA_W], b};
                            pend_valid_next  = 1'b1;
                            row_phase_next   = PH_CODE;
                        end
                        default:
                            row_phase_next = PH_CODE;
                    endcase
                end
            end
            else
            begin
                // checksum byte closes the packet
                if ((CHECKSUM_BASE - run_sum_reg) == b)
                begin
                    if (parse_fail_reg || (row_phase_reg != PH_CODE))
                        err_next = ERR_PARSE;
                    else
                    begin
                        ok_next = 1'b1;
                        if (pend_valid_reg)
                            commit_next = pend_sample_reg;
                    end
                end
                else
                    err_next = ERR_CHECKSUM;
                in_packet_next = 1'b0;
            end
        end

        // sync search, also right after a packet closes
        if (!in_packet_next && (b == SYNC_BYTE) && (prev_byte_reg == SYNC_BYTE))
        begin
            in_packet_next  = 1'b1;
            have_len_next   = 1'b0;
            byte_pos_next   = '0;
            run_sum_next    = '0;
            row_phase_next  = PH_CODE;
            pend_valid_next = 1'b0;
            parse_fail_next = 1'b0;
        end
    end

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_len_reg <= MAX_PAYLOAD_RESET;
        else if (cfg_write_en)
            max_len_reg <= cfg_write_data;
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s1_load)
            s1_valid_reg <= 1'b1;
        else if (s1_fire)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
            s1_byte_reg <= data_byte;
    end

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_byte_reg   <= '0;
            in_packet_reg   <= 1'b0;
            have_len_reg    <= 1'b0;
            byte_pos_reg    <= '0;
            payload_len_reg <= '0;
            run_sum_reg     <= '0;
            row_phase_reg   <= PH_CODE;
            pend_sample_reg <= '0;
            pend_valid_reg  <= 1'b0;
            parse_fail_reg  <= 1'b0;
            commit_reg      <= '0;
        end
        else if (s1_fire)
        begin
            prev_byte_reg   <= prev_byte_next;
            in_packet_reg   <= in_packet_next;
            have_len_reg    <= have_len_next;
            byte_pos_reg    <= byte_pos_next;
            payload_len_reg <= payload_len_next;
            run_sum_reg     <= run_sum_next;
            row_phase_reg   <= row_phase_next;
            pend_sample_reg <= pend_sample_next;
            pend_valid_reg  <= pend_valid_next;
            parse_fail_reg  <= parse_fail_next;
            commit_reg      <= commit_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            ok_reg  <= ok_next;
            err_reg <= err_next;
            raw_reg <= commit_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign packet_ok  = ok_reg;
    assign raw_value  = raw_reg;
    assign error_code = err_reg;

`ifndef NO_ASSERTIONS
    // a good packet never carries an error code
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && ok_next) |-> (err_next == ERR_NONE))
        else $error("packet_ok raised together with an error code");

    // input side stalls only while both registers are held
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg && out_stall))
        else $error("input stalled without a full pipeline");

    // the committed sample moves only on a good packet
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && !ok_next) |=> (commit_reg == $past(commit_reg)))
        else $error("raw value changed without a good packet");

    // a length abort leaves the packet unless the byte itself restarts sync
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && (err_next == ERR_LENGTH) && (b != SYNC_BYTE)) |=> !in_packet_reg)
        else $error("still in packet after a length abort");

    // no result beat is lost while the receiver stalls
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> out_valid_reg)
        else $error("result dropped while stalled");
`endif

endmodule

@@ bench/sync_length_checksum_packet_parser_top_tb.sv @@
// Self-checking bench for the sync/length/checksum packet parser top level.
// Predicts every result beat from the byte stream and compares it field by field.
// Depends on slcpp_pkg and sync_length_checksum_packet_parser_top.
`timescale 1ns / 100ps

module sync_length_checksum_packet_parser_top_tb;

    import slcpp_pkg::*;

    localparam int unsigned RESET_CYCLES   = 10;
    localparam int unsigned SETTLE_CYCLES  = 6;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned PRINT_LIMIT    = 40;
    localparam int unsigned RANDOM_BYTES   = 400;

    typedef logic [7:0] byte_q_t[$];

    typedef struct packed {
        logic        ok;
        logic [15:0] raw;
        err_code_t   err;
    } parse_result_t;

    // DUT signals
    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_write_en;
    logic [7:0]        cfg_write_data;
    logic              in_valid;
    logic              in_stall;
    logic [7:0]        data_byte;
    logic              out_valid;
    logic              out_stall;
    logic              packet_ok;
    logic [15:0]       raw_value;
    err_code_t         error_code;

    // Parser prediction state
    logic [7:0]        max_len;
    logic [7:0]        last_byte;
    logic              in_frame;
    logic              len_seen;
    logic [7:0]        taken;
    logic [7:0]        frame_len;
    logic [7:0]        sum;
    row_phase_t        phase;
    logic [15:0]       sample;
    logic              sample_ready;
    logic              row_broken;
    logic [15:0]       committed;

    // Expected result beats, oldest first
    parse_result_t     expected_q[$];
    parse_result_t     want;
    int unsigned       mismatch_count = 0;
    int unsigned       result_beats = 0;
    logic              steady = 1'b0;

    sync_length_checksum_packet_parser_top u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .data_byte      (data_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .packet_ok      (packet_ok),
        .raw_value      (raw_value),
        .error_code     (error_code)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Idle lengths: mostly short, now and then long
    function automatic int unsigned burst_len();
        if ($urandom_range(0, 99) < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic int unsigned pick_gap();
        if (steady || $urandom_range(0, 99) < 55)
            return 0;
        return burst_len();
    endfunction

    // Clear the prediction state as reset does
    function automatic void clear_parser();
        max_len      = MAX_PAYLOAD_RESET;
        last_byte    = '0;
        in_frame     = 1'b0;
        len_seen     = 1'b0;
        taken        = '0;
        frame_len    = '0;
        sum          = '0;
        phase        = PH_CODE;
        sample       = '0;
        sample_ready = 1'b0;
        row_broken   = 1'b0;
        committed    = '0;
    endfunction

    // Advance the prediction by one received byte, giving its result beat
    function automatic parse_result_t parse_byte(input logic [7:0] b);
        parse_result_t r;
        logic [7:0]    check_byte;
        r.ok  = 1'b0;
        r.err = ERR_NONE;
        if (in_frame)
        begin
            if (!len_seen)
            begin
                frame_len = b;
                len_seen  = 1'b1;
                taken     = '0;
                if (b > max_len)
                begin
                    in_frame = 1'b0;
                    r.err    = ERR_LENGTH;
                end
            end
            else if (taken < frame_len)
            begin
                sum   = sum + b;
                taken = taken + 8'd1;
                if (!row_broken)
                begin
                    case (phase)
                        PH_CODE:
                        begin
                            if (b != ROW_CODE)
                                row_broken = 1'b1;
                            else
                                phase = PH_LEN;
                        end
                        PH_LEN:  phase = PH_HIGH;
                        PH_HIGH:
                        begin
                            sample[15:8] = b;
                            phase        = PH_LOW;
                        end
                        default:
                        begin
                            sample[7:0]  = b;
                            sample_ready = 1'b1;
                            phase        = PH_CODE;
                        end
                    endcase
                end
            end
            else
            begin
                check_byte = CHECKSUM_BASE - sum;
                if (check_byte != b)
                    r.err = ERR_CHECKSUM;
                else if (row_broken || phase != PH_CODE)
                    r.err = ERR_PARSE;
                else
                begin
                    r.ok = 1'b1;
                    if (sample_ready)
                        committed = sample;
                end
                in_frame = 1'b0;
            end
        end
        // sync search runs after the in-frame work on every byte
        if (!in_frame && b == SYNC_BYTE && last_byte == SYNC_BYTE)
        begin
            in_frame     = 1'b1;
            len_seen     = 1'b0;
            taken        = '0;
            sum          = '0;
            phase        = PH_CODE;
            sample_ready = 1'b0;
            row_broken   = 1'b0;
        end
        last_byte = b;
        r.raw     = committed;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned exp_val);
        if (mismatch_count < PRINT_LIMIT)
            $display("error: result beat %0d %s: got 0x%0h, want 0x%0h",
                     result_beats, what, got, exp_val);
        mismatch_count++;
    endtask

    // Result checker: one expectation popped per accepted beat
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_q.size() == 0)
                report_mismatch("unexpected beat", 1, 0);
            else
            begin
                want = expected_q.pop_front();
                if (packet_ok !== want.ok)
                    report_mismatch("packet_ok", packet_ok, want.ok);
                if (raw_value !== want.raw)
                    report_mismatch("raw_value", raw_value, want.raw);
                if (error_code !== want.err)
                    report_mismatch("error_code", error_code, want.err);
            end
            result_beats++;
        end
    end

    // Receiver stalls
    initial
    begin : stall_gen
        int unsigned hold;
        hold = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold != 0)
            begin
                out_stall <= 1'b1;
                hold--;
            end
            else
            begin
                out_stall <= 1'b0;
                if (!steady && $urandom_range(0, 99) < 25)
                    hold = burst_len();
            end
        end
    end

    // Watchdog: ends the run after too long without any beat moving
    initial
    begin : watchdog
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Mismatches found");
        $finish;
    end

    // Send one byte beat, predict its result, then maybe leave a gap
    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        in_valid  <= 1'b1;
        data_byte <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_q.push_back(parse_byte(b));
        gap = pick_gap();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Hold off the sender until every expected beat has arrived
    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_max_length(input logic [7:0] v);
        drain_results();
        cfg_write_en   <= 1'b1;
        cfg_write_data <= v;
        @(posedge clk);
        cfg_write_en   <= 1'b0;
        max_len = v;
    endtask

    // Sync pair, length byte, payload, checksum (optionally corrupted)
    task automatic send_frame(input logic [7:0] len, input byte_q_t payload,
                              input bit bad_sum);
        logic [7:0] s;
        s = '0;
        send_byte(SYNC_BYTE);
        send_byte(SYNC_BYTE);
        send_byte(len);
        foreach (payload[i])
        begin
            s = s + payload[i];
            send_byte(payload[i]);
        end
        s = CHECKSUM_BASE - s;
        if (bad_sum)
            s = s ^ 8'($urandom_range(1, 255));
        send_byte(s);
    endtask

    function automatic byte_q_t make_rows(input int unsigned n);
        byte_q_t p;
        repeat (n)
        begin
            p.push_back(ROW_CODE);
            repeat (3) p.push_back(8'($urandom_range(0, 255)));
        end
        return p;
    endfunction

    // One random frame; mostly well formed, some broken, some line noise
    task automatic random_frame(output int unsigned sent);
        byte_q_t     p;
        int unsigned pick;
        int unsigned rows;
        int unsigned k;
        logic [7:0]  len;
        logic [7:0]  v;
        bit          bad_sum;
        pick    = $urandom_range(0, 99);
        rows    = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
        if (rows > max_len / 4)
            rows = max_len / 4;
        p       = make_rows(rows);
        bad_sum = (pick >= 70 && pick < 78);
        if (pick >= 95)
        begin
            // noise between frames, sync bytes included
            k    = $urandom_range(1, 6);
            sent = k;
            repeat (k)
                send_byte(($urandom_range(0, 3) == 0) ? SYNC_BYTE
                                                      : 8'($urandom_range(0, 255)));
            return;
        end
        if (pick >= 78 && pick < 84)
        begin
            // bad row code
            v = 8'($urandom_range(0, 255));
            if (v == ROW_CODE)
                v = v + 8'd1;
            if (rows == 0)
                p.push_back(v);
            else
                p[4 * $urandom_range(0, rows - 1)] = v;
        end
        else if (pick >= 84 && pick < 90)
        begin
            // payload ends part way through a row
            p.push_back(ROW_CODE);
            k = $urandom_range(0, 2);
            repeat (k) p.push_back(8'($urandom_range(0, 255)));
        end
        len = 8'(p.size());
        if (pick >= 90 && max_len != 8'hFF)
        begin
            // length above the maximum; the rest is noise
            len = 8'($urandom_range(max_len + 1, 255));
            while (p.size() > 4)
                void'(p.pop_back());
        end
        send_frame(len, p, bad_sum);
        sent = 4 + p.size();
    endtask

    task automatic random_stream(input int unsigned n_bytes);
        int unsigned total;
        int unsigned got;
        total = 0;
        while (total < n_bytes)
        begin
            random_frame(got);
            total += got;
        end
    endtask

    // Directed frames at the reset maximum of 169
    task automatic test_directed_frames();
        byte_q_t p;
        // one good row with extreme bytes
        p = {ROW_CODE, 8'h00, 8'hFF, 8'h01};
        send_frame(8'd4, p, 1'b0);
        // empty payload, raw value must hold
        p.delete();
        send_frame(8'd0, p, 1'b0);
        // length of 170 aborts, and with the sync byte before it opens a new frame
        send_byte(SYNC_BYTE);
        send_byte(SYNC_BYTE);
        send_byte(SYNC_BYTE);
        send_byte(8'h00);
        send_byte(8'hFF);
        // bad row code, good checksum
        p = {8'h81};
        send_frame(8'd1, p, 1'b0);
        // truncated row with a bad checksum: the checksum error wins
        p = {ROW_CODE};
        send_frame(8'd1, p, 1'b1);
    endtask

    // Maximum length at both extremes, with one full-size frame
    task automatic test_length_limits();
        byte_q_t p;
        write_max_length(8'd0);
        p.delete();
        send_frame(8'd0, p, 1'b0);
        p = make_rows(1);
        send_frame(8'd4, p, 1'b0);
        write_max_length(8'hFF);
        p = make_rows(63);
        send_frame(8'd252, p, 1'b0);
        p.push_back(ROW_CODE);
        p.push_back(8'h55);
        p.push_back(8'hAA);
        send_frame(8'd255, p, 1'b0);
    endtask

    // Random frames with no gaps and no stalls
    task automatic test_back_to_back();
        write_max_length(MAX_PAYLOAD_RESET);
        steady = 1'b1;
        random_stream(150);
        steady = 1'b0;
    endtask

    // Random frames over several maximum lengths
    task automatic test_random_traffic();
        write_max_length(8'($urandom_range(8, 40)));
        random_stream(RANDOM_BYTES / 4);
        write_max_length(8'hFF);
        random_stream(RANDOM_BYTES / 4);
        write_max_length(8'd16);
        random_stream(RANDOM_BYTES / 4);
        write_max_length(MAX_PAYLOAD_RESET);
        random_stream(RANDOM_BYTES / 4);
    endtask

    // Reset, tests in turn, final verdict
    initial
    begin
        rst_n          <= 1'b0;
        cfg_write_en   <= 1'b0;
        cfg_write_data <= '0;
        in_valid       <= 1'b0;
        data_byte      <= '0;
        clear_parser();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_frames();
        test_length_limits();
        test_back_to_back();
        test_random_traffic();

        drain_results();
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
